FILE: design/tsam_pkg.sv
// ----------------------------------------------------------------------------
// tsam_pkg
// shared types and codes for the tcp sequence/ack matcher
// ----------------------------------------------------------------------------
`default_nettype none

package tsam_pkg;

  typedef enum logic {
    OP_ADD = 1'b0,
    OP_ACK = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CLEAR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [31:0] seq;
    logic [15:0] len;
    logic        fin;
    logic [63:0] time_us;
  } entry_t;

  typedef struct packed {
    logic        valid;
    logic        found;
    logic [31:0] seq;
    logic        fin;
    logic [63:0] time_us;
  } res_t;

endpackage

`default_nettype wire

FILE: design/tsam_ram.sv
// ----------------------------------------------------------------------------
// tsam_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module tsam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: design/tsam_engine.sv
// ----------------------------------------------------------------------------
// tsam_engine
// ring write, ack scan over the entry ram and clearing of older entries
// ----------------------------------------------------------------------------
`default_nettype none

module tsam_engine
  import tsam_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_valid,
  input  wire logic        op,
  input  wire logic [31:0] seq_or_ack,
  input  wire logic [63:0] send_time,
  input  wire logic [15:0] payload_len,
  input  wire logic        fin_flag,
  output logic             idle,
  output res_t             res,
  input  wire logic        res_take
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  state_t state, state_next;

  logic [DEPTH-1:0] valid;
  logic [AW-1:0]    wp;
  logic [AW-1:0]    cnt;
  logic             issued_all;
  logic             rd_en;
  logic             rd_pend;
  logic [AW-1:0]    rd_idx;
  logic [31:0]      h;
  logic             have;
  logic [AW-1:0]    best_idx;
  logic [31:0]      best_seq;
  logic             best_fin;
  logic [63:0]      best_time;

  logic             we;
  entry_t           wentry;
  entry_t           rentry;
  logic [31:0]      seg_end;
  logic             hit;
  logic             better;
  logic             last_data;

  assign we     = idle && cmd_valid && (op == OP_ADD);
  assign wentry = '{seq: seq_or_ack, len: payload_len, fin: fin_flag, time_us: send_time};

  tsam_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (wp),
    .wdata (wentry),
    .re    (rd_en),
    .raddr (cnt),
    .rdata (rentry)
  );

  assign seg_end   = rentry.seq + {16'd0, rentry.len};
  assign hit       = valid[rd_idx] &&
                     ((rentry.seq == h) || ((rentry.seq <= h) && (h < seg_end)));
  assign better    = hit && (!have || (rentry.time_us < best_time));
  assign last_data = rd_pend && (rd_idx == LAST);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_valid && (op == OP_ACK)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_data) begin
          state_next = (have || better) ? ST_CLEAR : ST_DONE;
        end
      end
      ST_CLEAR: begin
        if (last_data) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    idle      = 1'b0;
    rd_en     = 1'b0;
    res.valid = 1'b0;
    case (state)
      ST_IDLE:  idle      = 1'b1;
      ST_SCAN:  rd_en     = !issued_all;
      ST_CLEAR: rd_en     = !issued_all;
      ST_DONE:  res.valid = 1'b1;
      default:  idle      = 1'b0;
    endcase
  end

  assign res.found   = have;
  assign res.seq     = best_seq;
  assign res.fin     = best_fin;
  assign res.time_us = best_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      valid      <= '0;
      wp         <= '0;
      cnt        <= '0;
      issued_all <= 1'b0;
      rd_pend    <= 1'b0;
      have       <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= rd_en;
      rd_idx  <= cnt;

      if (rd_en) begin
        cnt        <= (cnt == LAST) ? '0 : cnt + 1'b1;
        issued_all <= (cnt == LAST);
      end
      if (state != state_next) begin
        issued_all <= 1'b0;
      end

      // add a sent segment
      if (we) begin
        valid[wp] <= 1'b1;
        wp        <= (wp == LAST) ? '0 : wp + 1'b1;
      end

      // start an ack search
      if (idle && cmd_valid && (op == OP_ACK)) begin
        h         <= seq_or_ack - 32'd1;
        have      <= 1'b0;
        best_idx  <= '0;
        best_seq  <= '0;
        best_fin  <= 1'b0;
        best_time <= '0;
      end

      if ((state == ST_SCAN) && rd_pend && better) begin
        have      <= 1'b1;
        best_idx  <= rd_idx;
        best_seq  <= rentry.seq;
        best_fin  <= rentry.fin;
        best_time <= rentry.time_us;
      end

      if ((state == ST_CLEAR) && rd_pend) begin
        if (valid[rd_idx] && (rentry.time_us < best_time)) begin
          valid[rd_idx] <= 1'b0;
        end
        if (last_data) begin
          valid[best_idx] <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/tcp_seq_ack_matcher.sv
// ----------------------------------------------------------------------------
// tcp_seq_ack_matcher
// matches tcp acknowledgments against a ring of recorded sent segments
// ----------------------------------------------------------------------------
// input channel (in_valid/in_ready): op 0 records a sent segment, op 1 looks
// up an acknowledgment. output channel (out_valid/out_ready): one word per
// ack with found, sent_seq, sent_fin and sent_time (all zero if no match).
// an add gives no output word. an ack walks the entry ram one entry per
// cycle, first for the search and then, when a match is found, once more to
// retire older entries, before the word is handed to the output register.
// both walks go through the single read port of the entry ram. items are
// taken one at a time; in_ready is high only while no ack is in progress.
// the output register holds a finished word while the receiver stalls, and
// new adds and acks are accepted meanwhile; a following ack waits for the
// register before it completes.
// reset clears the outstanding marks, the ring pointer and out_valid only.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_seq_ack_matcher
  import tsam_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        op,
  input  wire logic [31:0] seq_or_ack,
  input  wire logic [63:0] send_time,
  input  wire logic [15:0] payload_len,
  input  wire logic        fin_flag,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             found,
  output logic [31:0]      sent_seq,
  output logic             sent_fin,
  output logic [63:0]      sent_time
);

  logic idle;
  res_t res;
  logic res_take;

  tsam_engine #(
    .DEPTH (DEPTH)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (in_valid && idle),
    .op          (op),
    .seq_or_ack  (seq_or_ack),
    .send_time   (send_time),
    .payload_len (payload_len),
    .fin_flag    (fin_flag),
    .idle        (idle),
    .res         (res),
    .res_take    (res_take)
  );

  assign in_ready = idle;
  assign res_take = res.valid && (!out_valid || out_ready);

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (res_take) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (res_take) begin
      found     <= res.found;
      sent_seq  <= res.seq;
      sent_fin  <= res.fin;
      sent_time <= res.time_us;
    end
  end

endmodule

`default_nettype wire

FILE: verif/tcp_seq_ack_matcher_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_seq_ack_matcher_tb
// self-checking bench for the tcp sequence/ack matcher
// ----------------------------------------------------------------------------
// a queue of segment records and acks, directed corner cases first and then
// random tcp-like flows mixed with noise, feeds a valid/ready driver. a
// scoreboard mirrors the segment ring, predicts the word of every ack and
// compares it field by field with what the block returns. both sides idle
// at random and the receiver holds off twice for a long stretch so the
// block backs up into its input.
// ----------------------------------------------------------------------------

module tcp_seq_ack_matcher_tb
  import tsam_pkg::*;
();

  localparam int DEPTH    = 16;
  localparam int N_ITEMS  = 1550;
  localparam int IDLE_MAX = 5000;
  localparam int LONG_HOLD = 400;

  typedef struct {
    op_t         op;
    logic [31:0] sa;
    logic [63:0] t;
    logic [15:0] len;
    logic        fin;
  } word_t;

  typedef struct {
    logic        found;
    logic [31:0] seq;
    logic        fin;
    logic [63:0] time_us;
  } ack_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  op_t         op = OP_ADD;
  logic [31:0] seq_or_ack = '0;
  logic [63:0] send_time = '0;
  logic [15:0] payload_len = '0;
  logic        fin_flag = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        found;
  logic [31:0] sent_seq;
  logic        sent_fin;
  logic [63:0] sent_time;

  word_t     pend[$];
  ack_word_t acks_due[$];

  // mirror of the segment ring
  logic        seg_valid[DEPTH];
  logic [31:0] seg_seq[DEPTH];
  logic [15:0] seg_len[DEPTH];
  logic        seg_fin[DEPTH];
  logic [63:0] seg_time[DEPTH];
  int          ring_ptr = 0;

  int          in_words = 0;
  int          n_items = 0;
  int          errors = 0;
  int          n_add = 0, n_hit = 0, n_miss = 0, n_holds = 0;
  int          gap_left = 0;
  int          hold_left = 0;
  int          hold_at = 500;
  logic [31:0] cyc = '0;
  int          idle_cnt = 0;
  wire         calm = (cyc[11:10] == 2'b11);

  tcp_seq_ack_matcher #(.DEPTH(DEPTH)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .seq_or_ack(seq_or_ack), .send_time(send_time),
    .payload_len(payload_len), .fin_flag(fin_flag),
    .out_valid(out_valid), .out_ready(out_ready),
    .found(found), .sent_seq(sent_seq), .sent_fin(sent_fin), .sent_time(sent_time)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      seg_valid[i] = 1'b0;
      seg_seq[i]   = '0;
      seg_len[i]   = '0;
      seg_fin[i]   = 1'b0;
      seg_time[i]  = '0;
    end
  end

  function automatic bit seq_covered(logic [31:0] s, logic [15:0] ln, logic [31:0] h);
    logic [31:0] e;
    e = s + {16'd0, ln};
    return (s == h) || (s <= h && h < e);
  endfunction

  function automatic ack_word_t match_ack(logic [31:0] ack);
    logic [31:0] h;
    bit          have;
    int          pick;
    ack_word_t   w;
    h = ack - 32'd1;
    have = 0;
    pick = 0;
    w = '{found: 1'b0, seq: '0, fin: 1'b0, time_us: '0};
    for (int i = 0; i < DEPTH; i++) begin
      if (seg_valid[i] && seq_covered(seg_seq[i], seg_len[i], h)) begin
        if (!have || seg_time[i] < seg_time[pick]) begin
          have = 1;
          pick = i;
        end
      end
    end
    if (have) begin
      w.found = 1'b1;
      w.seq = seg_seq[pick];
      w.fin = seg_fin[pick];
      w.time_us = seg_time[pick];
      for (int i = 0; i < DEPTH; i++)
        if (seg_valid[i] && seg_time[i] < w.time_us) seg_valid[i] = 1'b0;
      seg_valid[pick] = 1'b0;
      n_hit++;
    end else begin
      n_miss++;
    end
    return w;
  endfunction

  task automatic push_add(logic [31:0] s, logic [15:0] ln, logic f, logic [63:0] t);
    word_t w;
    w = '{op: OP_ADD, sa: s, t: t, len: ln, fin: f};
    pend.push_back(w);
  endtask

  task automatic push_ack(logic [31:0] a);
    word_t w;
    // fields other than the ack number are don't-care for a lookup
    w = '{op: OP_ACK, sa: a, t: {$urandom, $urandom}, len: 16'($urandom),
          fin: 1'($urandom)};
    pend.push_back(w);
  endtask

  function automatic logic [31:0] ack_for(logic [31:0] sq, logic [15:0] ln);
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return sq + {16'd0, ln} + ((ln == 0) ? 32'd1 : 32'd0);
    if (r < 80) return sq + 32'd1;
    if (r < 95) return sq + 32'd1 + $urandom_range(0, {16'd0, ln});
    return $urandom;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // stimulus
  initial begin
    int          r, nseg, j;
    logic [31:0] s;
    logic [63:0] t;
    logic [15:0] ln;
    logic        f;
    logic [31:0] fseq[$];
    logic [15:0] flen[$];

    // directed corners
    push_ack(32'h0);
    push_add(32'h0, 16'h0, 1'b0, 64'h0);
    push_ack(32'h1);
    push_add(32'hFFFF_FFFF, 16'hFFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    push_ack(32'h0);
    push_add(32'hFFFF_FFF0, 16'h0020, 1'b0, 64'd5);
    push_ack(32'hFFFF_FFF5);
    push_ack(32'hFFFF_FFF1);
    push_add(32'd500, 16'd10, 1'b0, 64'd50);
    push_add(32'd1000, 16'd100, 1'b0, 64'd100);
    push_add(32'd1000, 16'd100, 1'b1, 64'd100);
    push_ack(32'd1051);
    push_ack(32'd511);
    push_ack(32'd1100);
    push_ack(32'd1101);
    push_add(32'h0000_0010, 16'hFFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFE);
    push_add(32'h0000_0010, 16'h0001, 1'b0, 64'h8000_0000_0000_0000);
    push_ack(32'h0000_0011);
    push_ack(32'h0001_000F);
    push_ack(32'hFFFF_FFFF);

    while (pend.size() < N_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        if ($urandom_range(0, 1))
          push_add($urandom, 16'($urandom), 1'($urandom), {$urandom, $urandom});
        else
          push_ack($urandom);
      end else begin
        nseg = (r < 28) ? $urandom_range(17, 24) : $urandom_range(1, 8);
        s = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3000) : $urandom;
        t = $urandom_range(0, 1) ? {$urandom, $urandom} : 64'($urandom_range(0, 1000));
        fseq.delete();
        flen.delete();
        for (int k = 0; k < nseg; k++) begin
          r = $urandom_range(0, 99);
          if (r < 70) ln = 16'($urandom_range(0, 1460));
          else if (r < 80) ln = 16'd0;
          else ln = 16'($urandom);
          f = (k == nseg - 1) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 19) == 0);
          r = $urandom_range(0, 99);
          if (r < 92 || fseq.size() == 0) begin
            if (r < 80) t = t + 64'($urandom_range(1, 500));
            push_add(s, ln, f, t);
            fseq.push_back(s);
            flen.push_back(ln);
            s = s + {16'd0, ln} + {31'd0, f};
          end else begin
            // retransmission of an earlier segment with an older stamp
            j = $urandom_range(0, fseq.size() - 1);
            push_add(fseq[j], flen[j], 1'b0, t - 64'($urandom_range(1, 300)));
          end
          if ($urandom_range(0, 99) < 35) begin
            j = $urandom_range(0, fseq.size() - 1);
            push_ack(ack_for(fseq[j], flen[j]));
          end
        end
        repeat ($urandom_range(1, 3)) begin
          j = $urandom_range(0, fseq.size() - 1);
          push_ack(ack_for(fseq[j], flen[j]));
        end
      end
    end
    n_items = pend.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    wait (in_words == n_items);
    wait (acks_due.size() == 0);
    repeat (2 * DEPTH + 10) @(posedge clk);
    $display("run covered %0d words: %0d segment records, %0d acks (%0d matched, %0d missed)",
             n_items, n_add, n_hit + n_miss, n_hit, n_miss);
    $display("receiver held off %0d times for %0d cycles with the sender still offering",
             n_holds, LONG_HOLD);
    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // driver
  always @(posedge clk) begin : drv
    word_t w;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        in_words <= in_words + 1;
        if (op == OP_ADD) begin
          seg_valid[ring_ptr] = 1'b1;
          seg_seq[ring_ptr]   = seq_or_ack;
          seg_len[ring_ptr]   = payload_len;
          seg_fin[ring_ptr]   = fin_flag;
          seg_time[ring_ptr]  = send_time;
          ring_ptr = (ring_ptr + 1) % DEPTH;
          n_add++;
        end else begin
          acks_due.push_back(match_ack(seq_or_ack));
        end
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pend.size() > 0) begin
          w = pend.pop_front();
          op <= w.op;
          seq_or_ack <= w.sa;
          send_time <= w.t;
          payload_len <= w.len;
          fin_flag <= w.fin;
          in_valid <= 1'b1;
          gap_left = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (in_words >= hold_at) begin
      out_ready <= 1'b0;
      hold_left = LONG_HOLD - 1;
      hold_at = hold_at + 600;
      n_holds++;
    end else if (calm || $urandom_range(0, 99) < 65) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      hold_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 3) : $urandom_range(14, 79);
    end
  end

  task automatic report(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // monitor
  always @(posedge clk) begin : mon
    ack_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (acks_due.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual found=%0b seq=%0h fin=%0b t=%0h",
                 $time, found, sent_seq, sent_fin, sent_time);
        errors++;
      end else begin
        want = acks_due.pop_front();
        report("found", 64'(want.found), 64'(found));
        report("sent_seq", 64'(want.seq), 64'(sent_seq));
        report("sent_fin", 64'(want.fin), 64'(sent_fin));
        report("sent_time", want.time_us, sent_time);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= IDLE_MAX) begin
      $display("%0t: no progress for %0d cycles, %0d words pending", $time, IDLE_MAX,
               acks_due.size());
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
